[rtl/core/lptr_pkg.sv]
package lptr_pkg;

    // field and register widths
    localparam int COORD_W = 20;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 13;
    localparam int ELEV_W  = 15;
    localparam int SPAN_W  = 16;
    localparam int RANGE_W = 20;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 12;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 4096;

    // internal datapath widths
    localparam int SQ_W   = 2 * COORD_W - 1;
    localparam int RAD_W  = 58;
    localparam int ROOT_W = RAD_W / 2;
    localparam int CORD_W = 32;
    localparam int ANG_W  = 24;
    localparam int STEPS  = 18;
    localparam int NUM_W  = 36;
    localparam int DEN_W  = 24;
    localparam int QUO_W  = 17;
    localparam int DIV_CW = DEN_W + QUO_W;
    localparam int ELM_W  = ANG_W + 1;
    localparam int PROW_W = ELM_W + ROWS_W + 1;

    // angles in 1/25600 degree
    localparam logic signed [ANG_W-1:0] DEG90  = 24'sd2304000;
    localparam logic signed [ANG_W-1:0] DEG180 = 24'sd4608000;
    localparam logic signed [ANG_W:0]   DEG360 = 25'sd9216000;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [STEPS] = '{
        24'sd1152000, 24'sd680065, 24'sd359328, 24'sd182400, 24'sd91554,
        24'sd45822, 24'sd22916, 24'sd11459, 24'sd5730, 24'sd2865,
        24'sd1432, 24'sd716, 24'sd358, 24'sd179, 24'sd90,
        24'sd45, 24'sd22, 24'sd11
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS    = 3'd0,
        REG_IMAGE_COLUMNS = 3'd1,
        REG_MIN_ELEVATION = 3'd2,
        REG_MAX_ELEVATION = 3'd3,
        REG_AZIMUTH_SPAN  = 3'd4,
        REG_MAX_RANGE     = 3'd5,
        REG_INVERT_RANGE  = 3'd6,
        REG_NORMALIZE     = 3'd7
    } cfg_reg_t;

endpackage

[rtl/core/lidar_point_to_range_pixel_top.sv]
// throughput: one point per cycle unless stalled; the pipeline length is set by the 29-step
// square-root stages, the 18-step angle stages and the 18-step dividers
// the whole pipeline advances while the output register is empty or taken
// reset (async, active low) empties the pipeline and loads default settings
module lidar_point_to_range_pixel_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [lptr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lptr_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  point_valid,
    output logic                                  point_ready,
    input  logic signed [lptr_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [lptr_pkg::COORD_W-1:0]   y_coord,
    input  logic signed [lptr_pkg::COORD_W-1:0]   z_coord,
    output logic                                  pixel_valid,
    input  logic                                  pixel_ready,
    output logic [lptr_pkg::ROW_W-1:0]            pixel_row,
    output logic [lptr_pkg::COL_W-1:0]            pixel_column,
    output logic [lptr_pkg::RANGE_W-1:0]          pixel_value,
    output logic                                  in_image
);
    import lptr_pkg::*;

    localparam int LAT    = 71;
    localparam int Z_DLY  = 31;   // z from stage 1 to the elevation stages
    localparam int AZ_DLY = 31;   // azimuth from stage 19 to stage 50
    localparam int FL_DLY = 49;   // axis flags from stage 1 to stage 50
    localparam int RG_DLY = 18;   // range from stage 32 to stage 50
    localparam int DV_DLY = 18;   // alongside the dividers

    // ---------------- configuration registers ----------------
    logic [ROWS_W-1:0]         rows_reg;
    logic [COLS_W-1:0]         cols_reg;
    logic signed [ELEV_W-1:0]  min_el_reg;
    logic signed [ELEV_W-1:0]  max_el_reg;
    logic [SPAN_W-1:0]         span_reg;
    logic [RANGE_W-1:0]        max_range_reg;
    logic                      invert_reg;
    logic                      normalize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= 7'd16;
            cols_reg      <= 13'd720;
            min_el_reg    <= -15'sd1500;
            max_el_reg    <= 15'sd1500;
            span_reg      <= 16'd36000;
            max_range_reg <= 20'd50000;
            invert_reg    <= 1'b1;
            normalize_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_ROWS:    rows_reg      <= cfg_data[ROWS_W-1:0];
                REG_IMAGE_COLUMNS: cols_reg      <= cfg_data[COLS_W-1:0];
                REG_MIN_ELEVATION: min_el_reg    <= cfg_data[ELEV_W-1:0];
                REG_MAX_ELEVATION: max_el_reg    <= cfg_data[ELEV_W-1:0];
                REG_AZIMUTH_SPAN:  span_reg      <= cfg_data[SPAN_W-1:0];
                REG_MAX_RANGE:     max_range_reg <= cfg_data[RANGE_W-1:0];
                REG_INVERT_RANGE:  invert_reg    <= cfg_data[0];
                REG_NORMALIZE:     normalize_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // settings derived once; the user must change them only while the pipeline is empty, the block does not enforce it
    logic [ROWS_W-1:0]  rows_sat;
    logic [ROWS_W-1:0]  rows_m1;
    logic [COLS_W-1:0]  cols_sat;
    logic [COLS_W-1:0]  cols_dec;
    logic [COL_W-1:0]   cols_m1;
    logic [ELEV_W:0]    el_diff;
    logic [DEN_W-1:0]   den_row;
    logic [DEN_W-1:0]   den_col;
    logic [DEN_W-1:0]   den_val;
    logic               cfg_ok;

    assign rows_sat = (rows_reg > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_reg;
    assign rows_m1  = rows_sat - ROWS_W'(1);
    assign cols_sat = (cols_reg > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS) : cols_reg;
    assign cols_dec = cols_sat - COLS_W'(1);
    assign cols_m1  = cols_dec[COL_W-1:0];
    assign el_diff  = {max_el_reg[ELEV_W-1], max_el_reg} - {min_el_reg[ELEV_W-1], min_el_reg};
    assign den_row  = {1'b0, el_diff[ELEV_W-1:0], 8'b0};
    assign den_col  = {span_reg, 8'b0};
    assign den_val  = DEN_W'(max_range_reg);
    assign cfg_ok   = (rows_sat != '0) && (cols_sat != '0) &&
                      (max_el_reg > min_el_reg) && (span_reg != '0);

    // ---------------- pipeline control ----------------
    // one enable for every stage; valid bits shift with the data
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en          = !vld_reg[LAT-1] || pixel_ready;
    assign point_ready = en;
    assign pixel_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], point_valid};
    end

    // ---------------- stage 1: capture point ----------------
    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_coord;
            y_reg <= y_coord;
            z_reg <= z_coord;
        end
    end

    // point on the z axis bypasses both angle units
    logic [2:0] flags;
    assign flags = {(x_reg == '0) && (y_reg == '0),
                    !z_reg[COORD_W-1] && (z_reg != '0),
                    z_reg[COORD_W-1]};

    // azimuth: fold the left half plane onto the right, starting that half at 180 degrees
    logic signed [CORD_W-1:0] ax_s, ay_s, ax_in, ay_in;
    logic signed [ANG_W-1:0]  az_start, az_s19;

    assign ax_s = CORD_W'(x_reg) <<< 8;
    assign ay_s = CORD_W'(y_reg) <<< 8;

    always_comb
    begin
        if (x_reg[COORD_W-1])
        begin
            ax_in    = -ax_s;
            ay_in    = -ay_s;
            az_start = DEG180;
        end
        else
        begin
            ax_in    = ax_s;
            ay_in    = ay_s;
            az_start = '0;
        end
    end

    lptr_cordic u_az_cordic (
        .clk     (clk),
        .en      (en),
        .x_in    (ax_in),
        .y_in    (ay_in),
        .ang_in  (az_start),
        .ang_out (az_s19)
    );

    // ---------------- stages 2-3: squares and sums ----------------
    logic signed [2*COORD_W-1:0] xx_full, yy_full, zz_full;
    logic [SQ_W-1:0]             xx_reg, yy_reg, zz_reg;
    logic [SQ_W:0]               hsq_reg;
    logic [SQ_W+1:0]             sum_reg;

    assign xx_full = x_reg * x_reg;
    assign yy_full = y_reg * y_reg;
    assign zz_full = z_reg * z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= xx_full[SQ_W-1:0];
            yy_reg  <= yy_full[SQ_W-1:0];
            zz_reg  <= zz_full[SQ_W-1:0];
            hsq_reg <= {1'b0, xx_reg} + {1'b0, yy_reg};
            sum_reg <= {2'b0, xx_reg} + {2'b0, yy_reg} + {2'b0, zz_reg};
        end
    end

    // ---------------- stages 4-32: range and horizontal distance ----------------
    logic [ROOT_W-1:0] range_root, rho_root;

    lptr_isqrt u_range_sqrt (
        .clk      (clk),
        .en       (en),
        .rad_in   (RAD_W'(sum_reg)),
        .root_out (range_root)
    );

    // horizontal distance scaled by 256
    lptr_isqrt u_rho_sqrt (
        .clk      (clk),
        .en       (en),
        .rad_in   (RAD_W'({hsq_reg, 16'b0})),
        .root_out (rho_root)
    );

    // ---------------- alignment delay lines ----------------
    logic signed [COORD_W-1:0] zdl_reg  [Z_DLY];
    logic signed [ANG_W-1:0]   azdl_reg [AZ_DLY];
    logic [2:0]                fldl_reg [FL_DLY];
    logic [RANGE_W-1:0]        rgdl_reg [RG_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zdl_reg[0]  <= z_reg;
            azdl_reg[0] <= az_s19;
            fldl_reg[0] <= flags;
            rgdl_reg[0] <= range_root[RANGE_W-1:0];
            for (int i = 1; i < Z_DLY; i++)
                zdl_reg[i] <= zdl_reg[i-1];
            for (int i = 1; i < AZ_DLY; i++)
                azdl_reg[i] <= azdl_reg[i-1];
            for (int i = 1; i < FL_DLY; i++)
                fldl_reg[i] <= fldl_reg[i-1];
            for (int i = 1; i < RG_DLY; i++)
                rgdl_reg[i] <= rgdl_reg[i-1];
        end
    end

    // ---------------- stages 33-50: elevation ----------------
    logic signed [ANG_W-1:0] el_s50;

    lptr_cordic u_el_cordic (
        .clk     (clk),
        .en      (en),
        .x_in    (CORD_W'(rho_root)),
        .y_in    (CORD_W'(zdl_reg[Z_DLY-1]) <<< 8),
        .ang_in  ('0),
        .ang_out (el_s50)
    );

    // ---------------- stage 51: wrap, offset, clip ----------------
    logic                     axis_s50;
    logic signed [ANG_W-1:0]  az_s50;
    logic signed [ANG_W:0]    az_wrap;
    logic signed [ANG_W-1:0]  el_fix;
    logic [RANGE_W-1:0]       range_s50;
    logic [RANGE_W-1:0]       clipped;
    logic [ANG_W-1:0]         azw_next;
    logic signed [ELM_W-1:0]  elm_next;
    logic [RANGE_W-1:0]       val_next;

    assign axis_s50  = fldl_reg[FL_DLY-1][2];
    assign az_s50    = azdl_reg[AZ_DLY-1];
    assign range_s50 = rgdl_reg[RG_DLY-1];
    // only a negative angle can leave [0, 360)
    assign az_wrap   = ELM_W'(az_s50) + DEG360;

    always_comb
    begin
        if (axis_s50)
        begin
            azw_next = '0;
            if (fldl_reg[FL_DLY-1][1])
                el_fix = DEG90;
            else if (fldl_reg[FL_DLY-1][0])
                el_fix = -DEG90;
            else
                el_fix = '0;
        end
        else
        begin
            azw_next = az_s50[ANG_W-1] ? az_wrap[ANG_W-1:0] : az_s50;
            el_fix   = el_s50;
        end
        elm_next = ELM_W'(el_fix) - {{2{min_el_reg[ELEV_W-1]}}, min_el_reg, 8'b0};
        clipped  = (range_s50 < max_range_reg) ? range_s50 : max_range_reg;
        val_next = invert_reg ? (max_range_reg - clipped) : clipped;
    end

    logic [ANG_W-1:0]        azw_reg;
    logic signed [ELM_W-1:0] elm_reg;
    logic [RANGE_W-1:0]      val_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            azw_reg <= azw_next;
            elm_reg <= elm_next;
            val_reg <= val_next;
        end
    end

    // ---------------- stage 52: scale by image size ----------------
    logic signed [PROW_W-1:0] nrow_reg;
    logic [NUM_W-1:0]         ncol_reg;
    logic [NUM_W-1:0]         nval_reg;
    logic [RANGE_W-1:0]       val52_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrow_reg  <= elm_reg * $signed({1'b0, rows_m1});
            ncol_reg  <= azw_reg * cols_m1;
            nval_reg  <= {val_reg, 16'b0};
            val52_reg <= val_reg;
        end
    end

    // ---------------- stages 53-70: dividers ----------------
    logic [QUO_W-1:0] q_row, q_col, q_val;
    logic             ovf_row, ovf_col, ovf_val;

    // a negative numerator means a row below the window, rejected outright
    lptr_udiv u_row_div (
        .clk     (clk),
        .en      (en),
        .num_in  (NUM_W'(nrow_reg[PROW_W-2:0])),
        .den     (den_row),
        .quo_out (q_row),
        .ovf_out (ovf_row)
    );

    lptr_udiv u_col_div (
        .clk     (clk),
        .en      (en),
        .num_in  (ncol_reg),
        .den     (den_col),
        .quo_out (q_col),
        .ovf_out (ovf_col)
    );

    // value never exceeds max range, so this quotient stays within 17 bits
    lptr_udiv u_val_div (
        .clk     (clk),
        .en      (en),
        .num_in  (nval_reg),
        .den     (den_val),
        .quo_out (q_val),
        .ovf_out (ovf_val)
    );

    logic [RANGE_W:0] dvdl_reg [DV_DLY];   // {row numerator sign, value}

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvdl_reg[0] <= {nrow_reg[PROW_W-1], val52_reg};
            for (int i = 1; i < DV_DLY; i++)
                dvdl_reg[i] <= dvdl_reg[i-1];
        end
    end

    // ---------------- stage 71: bounds check and output register ----------------
    logic               row_neg;
    logic               row_ok, col_ok, inside_next;
    logic [ROWS_W-1:0]  row_full;
    logic [RANGE_W-1:0] value_next;

    assign row_neg  = dvdl_reg[DV_DLY-1][RANGE_W];
    assign row_ok   = !row_neg && !ovf_row && (q_row <= QUO_W'(rows_m1));
    assign col_ok   = !ovf_col && (q_col < QUO_W'(cols_sat));
    assign inside_next = cfg_ok && row_ok && col_ok;
    assign row_full = rows_m1 - q_row[ROWS_W-1:0];

    always_comb
    begin
        if (!normalize_reg)
            value_next = dvdl_reg[DV_DLY-1][RANGE_W-1:0];
        else if ((max_range_reg == '0) || ovf_val)
            value_next = '0;
        else
            value_next = RANGE_W'(q_val);
    end

    logic [ROW_W-1:0]   row_out_reg;
    logic [COL_W-1:0]   col_out_reg;
    logic [RANGE_W-1:0] value_out_reg;
    logic               inside_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_out_reg    <= inside_next ? row_full[ROW_W-1:0] : '0;
            col_out_reg    <= inside_next ? q_col[COL_W-1:0] : '0;
            value_out_reg  <= value_next;
            inside_out_reg <= inside_next;
        end
    end

    assign pixel_row    = row_out_reg;
    assign pixel_column = col_out_reg;
    assign pixel_value  = value_out_reg;
    assign in_image     = inside_out_reg;

endmodule

[rtl/core/lptr_isqrt.sv]
module lptr_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lptr_pkg::RAD_W-1:0]    rad_in,
    output logic [lptr_pkg::ROOT_W-1:0]   root_out
);
    import lptr_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    genvar s;
    for (s = 0; s < ROOT_W; s++)
    begin : g_bit
        localparam int K = ROOT_W - 1 - s;
        logic [RAD_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  trial;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0)
        begin : g_first
            assign rem_prev  = rad_in;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
        end

        // (q + 2^k)^2 - q^2 = q * 2^(k+1) + 2^(2k)
        assign trial = (RAD_W'(root_prev) << (K + 1)) | (RAD_W'(1) << (2 * K));

        always_comb
        begin
            if (rem_prev >= trial)
            begin
                rem_next  = rem_prev - trial;
                root_next = root_prev | (ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = rem_prev;
                root_next = root_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];

endmodule

[rtl/core/lptr_cordic.sv]
module lptr_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [lptr_pkg::CORD_W-1:0]  x_in,
    input  logic signed [lptr_pkg::CORD_W-1:0]  y_in,
    input  logic signed [lptr_pkg::ANG_W-1:0]   ang_in,
    output logic signed [lptr_pkg::ANG_W-1:0]   ang_out
);
    import lptr_pkg::*;

    logic signed [CORD_W-1:0] x_reg [STEPS];
    logic signed [CORD_W-1:0] y_reg [STEPS];
    logic signed [ANG_W-1:0]  a_reg [STEPS];

    genvar i;
    for (i = 0; i < STEPS; i++)
    begin : g_iter
        logic signed [CORD_W-1:0] x_prev, y_prev, x_next, y_next;
        logic signed [ANG_W-1:0]  a_prev, a_next;

        if (i == 0)
        begin : g_first
            assign x_prev = x_in;
            assign y_prev = y_in;
            assign a_prev = ang_in;
        end
        else
        begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign a_prev = a_reg[i-1];
        end

        // rotate toward the x axis, flooring shifts
        always_comb
        begin
            if (!y_prev[CORD_W-1] && (y_prev != '0))
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                a_next = a_prev + ATAN_TAB[i];
            end
            else
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                a_next = a_prev - ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                a_reg[i] <= a_next;
            end
        end
    end

    assign ang_out = a_reg[STEPS-1];

endmodule

[rtl/core/lptr_udiv.sv]
module lptr_udiv (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lptr_pkg::NUM_W-1:0]    num_in,
    input  logic [lptr_pkg::DEN_W-1:0]    den,
    output logic [lptr_pkg::QUO_W-1:0]    quo_out,
    output logic                          ovf_out
);
    import lptr_pkg::*;

    logic [NUM_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];

    // quotient too large for the restoring steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_in;
            quo_reg[0] <= '0;
            ovf_reg[0] <= DIV_CW'(num_in) >= (DIV_CW'(den) << QUO_W);
        end
    end

    genvar s;
    for (s = 1; s <= QUO_W; s++)
    begin : g_bit
        localparam int K = QUO_W - s;
        logic [DIV_CW-1:0] dsh;
        logic [NUM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        assign dsh = DIV_CW'(den) << K;

        always_comb
        begin
            if (DIV_CW'(rem_reg[s-1]) >= dsh)
            begin
                rem_next = rem_reg[s-1] - dsh[NUM_W-1:0];
                quo_next = quo_reg[s-1] | (QUO_W'(1) << K);
            end
            else
            begin
                rem_next = rem_reg[s-1];
                quo_next = quo_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quo_out = quo_reg[QUO_W];
    assign ovf_out = ovf_reg[QUO_W];

endmodule

[rtl/core/lptr_checker.sv]
module lptr_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  point_ready,
    input  logic                                  pixel_valid,
    input  logic                                  pixel_ready,
    input  logic [lptr_pkg::ROW_W-1:0]            pixel_row,
    input  logic [lptr_pkg::COL_W-1:0]            pixel_column,
    input  logic [lptr_pkg::RANGE_W-1:0]          pixel_value,
    input  logic                                  in_image
);

    // no pixel beat is offered while in reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !pixel_valid)
        else $error("pixel valid during reset");

    // a held pixel beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_row) &&
            $stable(pixel_column) && $stable(pixel_value) && $stable(in_image))
        else $error("pixel beat changed while stalled");

    // input side stalls only behind a held output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> pixel_valid && !pixel_ready)
        else $error("point ready low without output stall");

    // pixels outside the image carry zero indices
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !in_image |-> (pixel_row == '0) && (pixel_column == '0))
        else $error("nonzero index for pixel outside the image");

endmodule

bind lidar_point_to_range_pixel_top lptr_checker u_lptr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_ready  (point_ready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .pixel_value  (pixel_value),
    .in_image     (in_image)
);
